// File: src/fkht_pkg.sv
// ============================================================================
// Flow key hash table package
// Shared sizes, codes, storage layouts and the hash step.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fkht_pkg;

    // Table and pool sizes.
    localparam int BUCKETS     = 2048;
    localparam int BKT_W       = $clog2(BUCKETS);
    localparam int POOL_NODES  = 1024;
    localparam int NODE_W      = $clog2(POOL_NODES);
    localparam int LINK_W      = NODE_W + 1;
    localparam int RECORD_BITS = 32;

    // The empty marker for links is the pool size itself.
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);

    // Hash constants.
    localparam logic [31:0] GOLDEN = 32'h9e37_79b9;
    localparam int          ROT    = 5;

    // Commands carried by an input word.
    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } fkht_cmd_t;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_POOL_FULL = 2'd2;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_BKT_RD,
        S_BKT_WAIT,
        S_FIND_RD,
        S_FIND_WAIT,
        S_FREE_RD,
        S_FREE_WAIT,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WAIT,
        S_WALK_RD,
        S_WALK_WAIT,
        S_UNLINK,
        S_RELEASE,
        S_DONE
    } fkht_state_t;

    // Bucket table entry.
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] head;
    } fkht_bkt_t;

    // Node key: addresses, then family flag and ports.
    typedef struct packed {
        logic [63:0] src_low;
        logic [63:0] src_high;
        logic [63:0] dst_low;
        logic [63:0] dst_high;
        logic        v6;
        logic [15:0] dport;
        logic [15:0] sport;
    } fkht_key_t;

    // Node bookkeeping: in use flag, home bucket, chain link and record.
    typedef struct packed {
        logic                   in_use;
        logic [BKT_W-1:0]       bucket;
        logic [LINK_W-1:0]      next;
        logic [RECORD_BITS-1:0] record;
    } fkht_meta_t;

    // One hash step: XOR the word in, rotate left, multiply.
    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] x;
        logic [31:0] r;
        x = h ^ w;
        r = {x[31-ROT:0], x[31:32-ROT]};
        return r * GOLDEN;
    endfunction

endpackage

`default_nettype wire

// File: src/fkht_cmd_if.sv
// ============================================================================
// Flow key hash table command channel
// Valid/ready channel carrying one command word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface fkht_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic        is_ipv6;
    logic [63:0] src_addr_low;
    logic [63:0] src_addr_high;
    logic [63:0] dst_addr_low;
    logic [63:0] dst_addr_high;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] record_value;
    logic [9:0]  node_handle;

    modport source (
        output valid, command, is_ipv6, src_addr_low, src_addr_high,
               dst_addr_low, dst_addr_high, sport, dport,
               record_value, node_handle,
        input  ready
    );

    modport sink (
        input  valid, command, is_ipv6, src_addr_low, src_addr_high,
               dst_addr_low, dst_addr_high, sport, dport,
               record_value, node_handle,
        output ready
    );
endinterface

`default_nettype wire

// File: src/fkht_rsp_if.sv
// ============================================================================
// Flow key hash table response channel
// Valid/ready channel carrying one result word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface fkht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_record;
    logic [9:0]  result_handle;
    logic [10:0] bucket_index;

    modport source (
        output valid, status, found_record, result_handle, bucket_index,
        input  ready
    );

    modport sink (
        input  valid, status, found_record, result_handle, bucket_index,
        output ready
    );
endinterface

`default_nettype wire

// File: src/fkht_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fkht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: src/fkht_hash.sv
// ============================================================================
// Flow key hash unit
// Applies one XOR, rotate and multiply step per cycle over the key words.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fkht_hash
    import fkht_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             is_ipv6,
    input  wire logic [63:0]      src_addr_low,
    input  wire logic [63:0]      src_addr_high,
    input  wire logic [63:0]      dst_addr_low,
    input  wire logic [63:0]      dst_addr_high,
    input  wire logic [15:0]      sport,
    input  wire logic [15:0]      dport,
    output logic                  done,
    output logic [BKT_W-1:0]      bucket
);

    logic [3:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [31:0] h_reg;
    logic [31:0] word;
    logic        last;

    // Pick the word for the current step.
    always_comb
    begin
        word = 32'd0;
        if (is_ipv6)
        begin
            case (cnt_reg)
                4'd0:    word = src_addr_low[31:0];
                4'd1:    word = src_addr_low[63:32];
                4'd2:    word = src_addr_high[31:0];
                4'd3:    word = src_addr_high[63:32];
                4'd4:    word = {16'd0, sport};
                4'd5:    word = dst_addr_low[31:0];
                4'd6:    word = dst_addr_low[63:32];
                4'd7:    word = dst_addr_high[31:0];
                4'd8:    word = dst_addr_high[63:32];
                default: word = {16'd0, dport};
            endcase
        end
        else
        begin
            case (cnt_reg)
                4'd0:    word = src_addr_low[31:0];
                4'd1:    word = {16'd0, sport};
                4'd2:    word = dst_addr_low[31:0];
                default: word = {16'd0, dport};
            endcase
        end
        last = is_ipv6 ? (cnt_reg == 4'd9) : (cnt_reg == 4'd3);
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= run_reg && last;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 4'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (last)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Running hash value, one multiply per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h_reg <= 32'd0;
        end
        else if (run_reg)
        begin
            h_reg <= hash_step(h_reg, word);
        end
    end

    assign done   = done_reg;
    assign bucket = h_reg[BKT_W-1:0];

endmodule

`default_nettype wire

// File: src/flow_key_hash_table_unit.sv
// ============================================================================
// Flow key hash table unit
// Chained hash table of flow keys with a node pool, driven by commands.
// ============================================================================
// One command word is taken at a time and the unit is busy until its result
// word is built. The bucket hash runs on one shared multiplier, one key word
// per cycle, over four key words for IPv4 and ten for IPv6, and then raises a
// registered finish flag. A find walks the chain of its bucket until it hits
// the key or reaches the chain end; an insert takes a node from the free list
// first, else from the never-used part of the pool, and reports a full pool
// when both are empty. A delete reads its node first, then walks the chain of
// the node's bucket to it; it reports not found when the node is not in use
// or is missing from its chain. After reset, and for every clear command, a
// sweep resets all 2048 bucket entries and the in-use flag of every node;
// no command is taken meanwhile, and a clear command gives its result word
// after the sweep. The unit then returns to idle, where the next command can
// be taken. A finished result word waits in an output register, so a new
// command may be taken while it waits; a further result stalls until that
// register drains.
`timescale 1ns / 1ps
`default_nettype none

module flow_key_hash_table_unit
    import fkht_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fkht_cmd_if.sink  cmd,
    fkht_rsp_if.source rsp
);

    localparam int BKT_BITS  = $bits(fkht_bkt_t);
    localparam int KEY_BITS  = $bits(fkht_key_t);
    localparam int META_BITS = $bits(fkht_meta_t);

    fkht_state_t state_reg, state_next;

    // Captured command word.
    logic [1:0]             cmd_reg;
    fkht_key_t              key_reg;
    logic [RECORD_BITS-1:0] rec_reg;
    logic [NODE_W-1:0]      handle_reg;

    // Working registers.
    logic [BKT_W-1:0]  sweep_reg, sweep_next;
    logic [BKT_W-1:0]  bkt_reg, bkt_next;
    logic [LINK_W-1:0] n_reg, n_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    logic [LINK_W-1:0] bhead_reg, bhead_next;
    logic [NODE_W-1:0] alloc_reg, alloc_next;
    fkht_meta_t        prev_meta_reg, prev_meta_next;
    fkht_meta_t        hmeta_reg, hmeta_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] fresh_reg, fresh_next;

    // Result held until the output register is free.
    logic [1:0]             res_status_reg, res_status_next;
    logic [RECORD_BITS-1:0] res_rec_reg, res_rec_next;
    logic [NODE_W-1:0]      res_rh_reg, res_rh_next;
    logic [BKT_W-1:0]       res_bi_reg, res_bi_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg;
    logic [RECORD_BITS-1:0] out_rec_reg;
    logic [NODE_W-1:0]      out_rh_reg;
    logic [BKT_W-1:0]       out_bi_reg;
    logic                   out_load;

    // Memory ports.
    logic              bkt_we;
    fkht_bkt_t         bkt_wdata;
    logic [BKT_W-1:0]  bkt_waddr;
    fkht_bkt_t         bkt_rdata;
    logic              key_we;
    fkht_key_t         key_rdata;
    logic              meta_we;
    logic [NODE_W-1:0] meta_waddr;
    fkht_meta_t        meta_wdata;
    fkht_meta_t        meta_rdata;
    logic [NODE_W-1:0] node_raddr;

    logic              hash_start;
    logic              hash_done;
    logic [BKT_W-1:0]  hash_bucket;
    logic              accept;
    logic [LINK_W-1:0] head_link;

    assign accept = cmd.valid && cmd.ready;

    // Shared hash unit.
    fkht_hash u_hash (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (hash_start),
        .is_ipv6       (key_reg.v6),
        .src_addr_low  (key_reg.src_low),
        .src_addr_high (key_reg.src_high),
        .dst_addr_low  (key_reg.dst_low),
        .dst_addr_high (key_reg.dst_high),
        .sport         (key_reg.sport),
        .dport         (key_reg.dport),
        .done          (hash_done),
        .bucket        (hash_bucket)
    );

    // Bucket table: valid flag and chain head.
    fkht_ram #(.WIDTH(BKT_BITS), .DEPTH(BUCKETS)) u_bkt_ram (
        .clk     (clk),
        .wr_en   (bkt_we),
        .wr_addr (bkt_waddr),
        .wr_data (bkt_wdata),
        .rd_addr (bkt_reg),
        .rd_data (bkt_rdata)
    );

    // Node keys.
    fkht_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_NODES)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (alloc_reg),
        .wr_data (key_reg),
        .rd_addr (node_raddr),
        .rd_data (key_rdata)
    );

    // Node bookkeeping.
    fkht_ram #(.WIDTH(META_BITS), .DEPTH(POOL_NODES)) u_meta_ram (
        .clk     (clk),
        .wr_en   (meta_we),
        .wr_addr (meta_waddr),
        .wr_data (meta_wdata),
        .rd_addr (node_raddr),
        .rd_data (meta_rdata)
    );

    assign head_link = bkt_rdata.valid ? {1'b0, bkt_rdata.head} : NIL;

    // State register. The sweep after reset must not produce a result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            free_head_reg <= NIL;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_FIND;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                cmd_reg <= cmd.command;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.src_low  <= cmd.src_addr_low;
            key_reg.src_high <= cmd.src_addr_high;
            key_reg.dst_low  <= cmd.dst_addr_low;
            key_reg.dst_high <= cmd.dst_addr_high;
            key_reg.v6       <= cmd.is_ipv6;
            key_reg.dport    <= cmd.dport;
            key_reg.sport    <= cmd.sport;
            rec_reg          <= cmd.record_value[RECORD_BITS-1:0];
            handle_reg       <= cmd.node_handle;
        end
        bkt_reg         <= bkt_next;
        n_reg           <= n_next;
        prev_reg        <= prev_next;
        steps_reg       <= steps_next;
        bhead_reg       <= bhead_next;
        alloc_reg       <= alloc_next;
        prev_meta_reg   <= prev_meta_next;
        hmeta_reg       <= hmeta_next;
        res_status_reg  <= res_status_next;
        res_rec_reg     <= res_rec_next;
        res_rh_reg      <= res_rh_next;
        res_bi_reg      <= res_bi_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_rec_reg    <= res_rec_reg;
            out_rh_reg     <= res_rh_reg;
            out_bi_reg     <= res_bi_reg;
        end
    end

    // Sequencer: next state, memory controls and result.
    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        bkt_next        = bkt_reg;
        n_next          = n_reg;
        prev_next       = prev_reg;
        steps_next      = steps_reg;
        bhead_next      = bhead_reg;
        alloc_next      = alloc_reg;
        prev_meta_next  = prev_meta_reg;
        hmeta_next      = hmeta_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        res_rh_next     = res_rh_reg;
        res_bi_next     = res_bi_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_load        = 1'b0;
        hash_start      = 1'b0;
        bkt_we          = 1'b0;
        bkt_waddr       = bkt_reg;
        bkt_wdata       = '0;
        key_we          = 1'b0;
        meta_we         = 1'b0;
        meta_waddr      = handle_reg;
        meta_wdata      = '0;
        node_raddr      = n_reg[NODE_W-1:0];
        cmd.ready       = 1'b0;

        unique case (state_reg)
            // Reset every bucket and every in-use flag, one entry a cycle.
            S_SWEEP:
            begin
                bkt_we     = 1'b1;
                bkt_waddr  = sweep_reg;
                meta_we    = (sweep_reg < BKT_W'(POOL_NODES));
                meta_waddr = sweep_reg[NODE_W-1:0];
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == BKT_W'(BUCKETS - 1))
                begin
                    free_head_next  = NIL;
                    fresh_next      = '0;
                    res_status_next = ST_OK;
                    res_rec_next    = '0;
                    res_rh_next     = '0;
                    res_bi_next     = '0;
                    state_next      = (cmd_reg == CMD_CLEAR) ? S_DONE : S_IDLE;
                end
            end

            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    sweep_next = '0;
                    unique case (cmd.command) inside
                        CMD_FIND, CMD_INSERT:
                        begin
                            hash_start = 1'b1;
                            state_next = S_HASH;
                        end
                        CMD_DELETE:
                        begin
                            state_next = S_DEL_RD;
                        end
                        default:
                        begin
                            state_next = S_SWEEP;
                        end
                    endcase
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    bkt_next   = hash_bucket;
                    state_next = S_BKT_RD;
                end
            end

            S_BKT_RD:
            begin
                state_next = S_BKT_WAIT;
            end

            // Bucket entry is here: dispatch on the command.
            S_BKT_WAIT:
            begin
                steps_next = '0;
                n_next     = head_link;
                prev_next  = NIL;
                bhead_next = head_link;
                if (cmd_reg == CMD_FIND)
                begin
                    state_next = S_FIND_RD;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    if (free_head_reg != NIL)
                    begin
                        state_next = S_FREE_RD;
                    end
                    else if (fresh_reg != NIL)
                    begin
                        alloc_next = fresh_reg[NODE_W-1:0];
                        fresh_next = fresh_reg + 1'b1;
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        res_status_next = ST_POOL_FULL;
                        res_rec_next    = '0;
                        res_rh_next     = '0;
                        res_bi_next     = bkt_reg;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end

            // Find: visit one chain node per pass.
            S_FIND_RD:
            begin
                if (n_reg != NIL && steps_reg != NIL)
                begin
                    state_next = S_FIND_WAIT;
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_rec_next    = '0;
                    res_rh_next     = '0;
                    res_bi_next     = bkt_reg;
                    state_next      = S_DONE;
                end
            end

            S_FIND_WAIT:
            begin
                if (key_rdata == key_reg)
                begin
                    res_status_next = ST_OK;
                    res_rec_next    = meta_rdata.record;
                    res_rh_next     = n_reg[NODE_W-1:0];
                    res_bi_next     = bkt_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    n_next     = meta_rdata.next;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end

            // Insert: pop the free list head.
            S_FREE_RD:
            begin
                node_raddr = free_head_reg[NODE_W-1:0];
                state_next = S_FREE_WAIT;
            end

            S_FREE_WAIT:
            begin
                alloc_next     = free_head_reg[NODE_W-1:0];
                free_head_next = meta_rdata.next;
                state_next     = S_INS_WR;
            end

            S_INS_WR:
            begin
                key_we            = 1'b1;
                meta_we           = 1'b1;
                meta_waddr        = alloc_reg;
                meta_wdata.in_use = 1'b1;
                meta_wdata.bucket = bkt_reg;
                meta_wdata.next   = bhead_reg;
                meta_wdata.record = rec_reg;
                bkt_we            = 1'b1;
                bkt_wdata.valid   = 1'b1;
                bkt_wdata.head    = alloc_reg;
                res_status_next   = ST_OK;
                res_rec_next      = '0;
                res_rh_next       = alloc_reg;
                res_bi_next       = bkt_reg;
                state_next        = S_DONE;
            end

            // Delete: look up the node to find its bucket.
            S_DEL_RD:
            begin
                node_raddr = handle_reg;
                state_next = S_DEL_WAIT;
            end

            S_DEL_WAIT:
            begin
                hmeta_next = meta_rdata;
                bkt_next   = meta_rdata.bucket;
                if (meta_rdata.in_use)
                begin
                    state_next = S_BKT_RD;
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_rec_next    = '0;
                    res_rh_next     = '0;
                    res_bi_next     = '0;
                    state_next      = S_DONE;
                end
            end

            // Delete: walk the chain to the node, keeping its predecessor.
            S_WALK_RD:
            begin
                if (n_reg == {1'b0, handle_reg})
                begin
                    state_next = S_UNLINK;
                end
                else if (n_reg == NIL || steps_reg == NIL)
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_rec_next    = '0;
                    res_rh_next     = '0;
                    res_bi_next     = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_WALK_WAIT;
                end
            end

            S_WALK_WAIT:
            begin
                prev_next      = n_reg;
                prev_meta_next = meta_rdata;
                n_next         = meta_rdata.next;
                steps_next     = steps_reg + 1'b1;
                state_next     = S_WALK_RD;
            end

            // Bypass the node from its predecessor or from the bucket.
            S_UNLINK:
            begin
                if (prev_reg != NIL)
                begin
                    meta_we         = 1'b1;
                    meta_waddr      = prev_reg[NODE_W-1:0];
                    meta_wdata      = prev_meta_reg;
                    meta_wdata.next = hmeta_reg.next;
                end
                else
                begin
                    bkt_we          = 1'b1;
                    bkt_wdata.valid = (hmeta_reg.next != NIL);
                    bkt_wdata.head  = hmeta_reg.next[NODE_W-1:0];
                end
                state_next = S_RELEASE;
            end

            // Push the node onto the free list.
            S_RELEASE:
            begin
                meta_we           = 1'b1;
                meta_waddr        = handle_reg;
                meta_wdata.in_use = 1'b0;
                meta_wdata.bucket = hmeta_reg.bucket;
                meta_wdata.next   = free_head_reg;
                meta_wdata.record = hmeta_reg.record;
                free_head_next    = {1'b0, handle_reg};
                res_status_next   = ST_OK;
                res_rec_next      = hmeta_reg.record;
                res_rh_next       = handle_reg;
                res_bi_next       = bkt_reg;
                state_next        = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.found_record  = out_rec_reg;
    assign rsp.result_handle = out_rh_reg;
    assign rsp.bucket_index  = out_bi_reg;

    // The free list only ever holds nodes that were handed out before.
    a_free_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg != NIL |-> fresh_reg != '0)
        else $error("free list non-empty while no node was ever allocated");

    // The fresh count never passes the pool size.
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= NIL)
        else $error("fresh node count beyond pool size");

    // The hash unit only finishes while the sequencer waits for it.
    a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == S_HASH)
        else $error("hash finished outside the hash state");

    // A clear command always starts a sweep.
    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == CMD_CLEAR |=> state_reg == S_SWEEP)
        else $error("clear command did not start a sweep");

endmodule

`default_nettype wire
